[sv/vrrd_pkg.sv]
// ----------------------------------------------------------------------------
// vrrd_pkg
// Shared types and constants of the RTC rate divider.
// ----------------------------------------------------------------------------
`default_nettype none

package vrrd_pkg;

    localparam int CHANNELS  = 3;
    localparam int BASE_RATE = 1024;
    localparam int MIN_RATE  = 2;

    localparam int KIND_W    = 3;
    localparam int CHAN_W    = 2;
    localparam int FREQ_W    = 16;
    localparam int BYTES_W   = 4;
    localparam int ALL_W     = 3;

    localparam int REQUIRED_BYTES = 4;
    localparam int OPEN_RELOAD    = BASE_RATE / MIN_RATE;
    localparam int CNT_W          = $clog2(OPEN_RELOAD + 1);
    localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LG_W           = $clog2(FREQ_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_RATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_ARM = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POLL     = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_SET_RATE,
        OP_REJECT,
        OP_OPEN,
        OP_CLOSE,
        OP_READ_ARM
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                ch_ok;
        logic [CH_IDX_W-1:0] ch;
        logic [CNT_W-1:0]    reload;
    } cmd_t;

endpackage

`default_nettype wire

[sv/vrrd_req_if.sv]
// ----------------------------------------------------------------------------
// vrrd_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrrd_req_if;
    logic                         valid;
    logic                         ready;
    logic [vrrd_pkg::KIND_W-1:0]  kind;
    logic [vrrd_pkg::CHAN_W-1:0]  channel;
    logic [vrrd_pkg::FREQ_W-1:0]  freq_value;
    logic [vrrd_pkg::BYTES_W-1:0] byte_count;

    modport source (output valid, kind, channel, freq_value, byte_count, input ready);
    modport sink   (input valid, kind, channel, freq_value, byte_count, output ready);
endinterface

`default_nettype wire

[sv/vrrd_rsp_if.sv]
// ----------------------------------------------------------------------------
// vrrd_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrrd_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic                       flag;
    logic [vrrd_pkg::ALL_W-1:0] all_flags;

    modport source (output valid, status, flag, all_flags, input ready);
    modport sink   (input valid, status, flag, all_flags, output ready);
endinterface

`default_nettype wire

[sv/virtual_rtc_rate_divider.sv]
// A result word is registered in the back end after its request leaves the queue.
// Throughput: one word in and one command executed per cycle unless rsp stalls.
// A two-entry command queue lets intake continue while a result waits on the output.
// Reset (rst_n low, asynchronous) clears counters, active and event flags, the
// shared reload, the queue and the output valid.
// ----------------------------------------------------------------------------
// virtual_rtc_rate_divider
// Three-channel divider of a base tick with a shared power-of-two reload.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_rtc_rate_divider (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vrrd_req_if.sink   req,
    vrrd_rsp_if.source rsp
);

    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;
    vrrd_pkg::cmd_t push_cmd;
    vrrd_pkg::cmd_t head_cmd;

    vrrd_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    vrrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    vrrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[sv/vrrd_front.sv]
// ----------------------------------------------------------------------------
// vrrd_front
// Accept request words, decode them and check set-rate arguments.
// ----------------------------------------------------------------------------
`default_nettype none

module vrrd_front (
    vrrd_req_if.sink        req,
    input  wire logic       full,
    output logic            push,
    output vrrd_pkg::cmd_t  cmd
);

    logic                        pow2;
    logic                        rate_ok;
    logic [vrrd_pkg::LG_W-1:0]   lg;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        lg = '0;
        for (int k = 0; k < vrrd_pkg::FREQ_W; k++)
        begin
            if (req.freq_value[k])
            begin
                lg = vrrd_pkg::LG_W'(k);
            end
        end
    end

    assign pow2    = (req.freq_value != '0) &&
                     ((req.freq_value & (req.freq_value - 1'b1)) == '0);
    assign rate_ok = pow2 &&
                     (int'(req.freq_value) >= vrrd_pkg::MIN_RATE) &&
                     (int'(req.freq_value) <= vrrd_pkg::BASE_RATE);

    always_comb
    begin
        cmd.ch_ok  = int'(req.channel) < vrrd_pkg::CHANNELS;
        cmd.ch     = vrrd_pkg::CH_IDX_W'(req.channel);
        cmd.reload = vrrd_pkg::CNT_W'(vrrd_pkg::BASE_RATE >> lg);
        case (req.kind)
            vrrd_pkg::KIND_TICK:
                cmd.op = vrrd_pkg::OP_TICK;
            vrrd_pkg::KIND_SET_RATE:
            begin
                if ((int'(req.byte_count) == vrrd_pkg::REQUIRED_BYTES) && rate_ok)
                    cmd.op = vrrd_pkg::OP_SET_RATE;
                else
                    cmd.op = vrrd_pkg::OP_REJECT;
            end
            vrrd_pkg::KIND_OPEN:
                cmd.op = vrrd_pkg::OP_OPEN;
            vrrd_pkg::KIND_CLOSE:
                cmd.op = vrrd_pkg::OP_CLOSE;
            vrrd_pkg::KIND_READ_ARM:
                cmd.op = vrrd_pkg::OP_READ_ARM;
            default:
                cmd.op = vrrd_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[sv/vrrd_queue.sv]
// ----------------------------------------------------------------------------
// vrrd_queue
// Short command queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module vrrd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire vrrd_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output vrrd_pkg::cmd_t       head_cmd
);

    vrrd_pkg::cmd_t                   entry_reg [vrrd_pkg::QUEUE_DEPTH];
    logic [vrrd_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [vrrd_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [vrrd_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign full      = (int'(count_reg) == vrrd_pkg::QUEUE_DEPTH);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (int'(wr_ptr_reg) == vrrd_pkg::QUEUE_DEPTH - 1)
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (int'(rd_ptr_reg) == vrrd_pkg::QUEUE_DEPTH - 1)
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/vrrd_back.sv]
// ----------------------------------------------------------------------------
// vrrd_back
// Execute commands on channel state and register the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module vrrd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            not_empty,
    input  wire vrrd_pkg::cmd_t  cmd,
    output logic                 pop,
    vrrd_rsp_if.source           rsp
);

    logic [vrrd_pkg::CNT_W-1:0]    count_reg  [vrrd_pkg::CHANNELS];
    logic [vrrd_pkg::CNT_W-1:0]    count_next [vrrd_pkg::CHANNELS];
    logic [vrrd_pkg::CHANNELS-1:0] active_reg, active_next;
    logic [vrrd_pkg::CHANNELS-1:0] event_reg, event_next;
    logic [vrrd_pkg::CNT_W-1:0]    reload_reg, reload_next;

    logic                          valid_reg;
    logic                          status_reg, status_next;
    logic                          flag_reg, flag_next;
    logic [vrrd_pkg::ALL_W-1:0]    all_reg, all_next;

    assign pop = not_empty && (!valid_reg || rsp.ready);

    assign rsp.valid     = valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.flag      = flag_reg;
    assign rsp.all_flags = all_reg;

    always_comb
    begin
        count_next  = count_reg;
        active_next = active_reg;
        event_next  = event_reg;
        reload_next = reload_reg;
        status_next = 1'b0;
        case (cmd.op)
            vrrd_pkg::OP_TICK:
            begin
                for (int i = 0; i < vrrd_pkg::CHANNELS; i++)
                begin
                    if (active_reg[i])
                    begin
                        if (count_reg[i] <= vrrd_pkg::CNT_W'(1))
                        begin
                            count_next[i] = reload_reg;
                            event_next[i] = 1'b1;
                        end
                        else
                        begin
                            count_next[i] = count_reg[i] - 1'b1;
                        end
                    end
                end
            end
            vrrd_pkg::OP_SET_RATE:
                reload_next = cmd.reload;
            vrrd_pkg::OP_REJECT:
                status_next = 1'b1;
            vrrd_pkg::OP_OPEN:
            begin
                if (cmd.ch_ok)
                begin
                    active_next[cmd.ch] = 1'b1;
                    count_next[cmd.ch]  = vrrd_pkg::CNT_W'(vrrd_pkg::OPEN_RELOAD);
                    reload_next         = vrrd_pkg::CNT_W'(vrrd_pkg::OPEN_RELOAD);
                end
            end
            vrrd_pkg::OP_CLOSE:
            begin
                if (cmd.ch_ok)
                    active_next[cmd.ch] = 1'b0;
            end
            vrrd_pkg::OP_READ_ARM:
            begin
                if (cmd.ch_ok && active_reg[cmd.ch])
                    event_next[cmd.ch] = 1'b0;
            end
            default:
            begin
            end
        endcase

        flag_next = cmd.ch_ok && event_next[cmd.ch];
        all_next  = '0;
        for (int i = 0; i < vrrd_pkg::ALL_W; i++)
        begin
            if (i < vrrd_pkg::CHANNELS)
                all_next[i] = event_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vrrd_pkg::CHANNELS; i++)
            begin
                count_reg[i] <= '0;
            end
            active_reg <= '0;
            event_reg  <= '0;
            reload_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg  <= count_next;
                active_reg <= active_next;
                event_reg  <= event_next;
                reload_reg <= reload_next;
                valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            flag_reg   <= flag_next;
            all_reg    <= all_next;
        end
    end

endmodule

`default_nettype wire

[tb/sv/virtual_rtc_rate_divider_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// virtual_rtc_rate_divider_test
// Self-checking bench for the three-channel RTC rate divider. Each accepted
// request word is run through a cycle-free model of the channel counters,
// flags and shared reload, and the predicted result word is queued. Each
// result word is compared field by field with the oldest prediction. Both
// sides idle at random: the request side in bursts, the result side on
// rotating ready patterns.
// ----------------------------------------------------------------------------

module virtual_rtc_rate_divider_test;

    import vrrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic             status;
        logic             flag;
        logic [ALL_W-1:0] all_flags;
    } rtc_word_t;

    class rtc_divider_scoreboard;
        logic [CNT_W-1:0] ticks_left [CHANNELS];
        bit               running    [CHANNELS];
        bit               raised     [CHANNELS];
        logic [CNT_W-1:0] reload_value;
        rtc_word_t        expected_words [$];
        int unsigned      errors;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                ticks_left[i] = '0;
                running[i]    = 1'b0;
                raised[i]     = 1'b0;
            end
            reload_value = '0;
            errors       = 0;
        endfunction

        function bit rate_valid(logic [FREQ_W-1:0] freq);
            return freq >= MIN_RATE && freq <= BASE_RATE
                && (freq & (freq - 1'b1)) == '0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] ch,
                                   logic [FREQ_W-1:0] freq, logic [BYTES_W-1:0] nbytes);
            rtc_word_t word;
            bit        ch_ok;
            word  = '0;
            ch_ok = ch < CHANNELS;
            if (kind == KIND_TICK)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (running[i])
                    begin
                        if (ticks_left[i] <= 1)
                        begin
                            ticks_left[i] = reload_value;
                            raised[i]     = 1'b1;
                        end
                        else
                        begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
            end
            else if (kind == KIND_SET_RATE)
            begin
                if (nbytes != BYTES_W'(REQUIRED_BYTES) || !rate_valid(freq))
                    word.status = 1'b1;
                else
                    reload_value = CNT_W'(BASE_RATE / int'(freq));
            end
            else if (ch_ok)
            begin
                if (kind == KIND_OPEN)
                begin
                    running[ch]    = 1'b1;
                    ticks_left[ch] = CNT_W'(OPEN_RELOAD);
                    reload_value   = CNT_W'(OPEN_RELOAD);
                end
                else if (kind == KIND_CLOSE)
                begin
                    running[ch] = 1'b0;
                end
                else if (kind == KIND_READ_ARM && running[ch])
                begin
                    raised[ch] = 1'b0;
                end
            end
            if (ch_ok)
                word.flag = raised[ch];
            for (int i = 0; i < CHANNELS; i++)
                word.all_flags[i] = raised[i];
            expected_words.push_back(word);
        endfunction

        function void check_result(logic status, logic flag, logic [ALL_W-1:0] all_flags);
            rtc_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with no request pending: status %0d flag %0d all_flags %0d",
                       status, flag, all_flags);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    errors++;
                end
                if (flag !== want.flag)
                begin
                    $error("flag: expected %0d, actual %0d", want.flag, flag);
                    errors++;
                end
                if (all_flags !== want.all_flags)
                begin
                    $error("all_flags: expected %0d, actual %0d", want.all_flags, all_flags);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vrrd_req_if req ();
    vrrd_rsp_if rsp ();

    virtual_rtc_rate_divider DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rtc_divider_scoreboard rates;
    int unsigned           burst_left = 0;
    int unsigned           quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [FREQ_W-1:0] good_rate();
        int unsigned lg;
        lg = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : $urandom_range(5, 10);
        return FREQ_W'(1) << lg;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] ch,
                             input logic [FREQ_W-1:0] freq, input logic [BYTES_W-1:0] nbytes);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid      <= 1'b1;
        req.kind       <= kind;
        req.channel    <= ch;
        req.freq_value <= freq;
        req.byte_count <= nbytes;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // calm: hold channels open and running so the counters drain
    task automatic send_random(input int unsigned tick_pct, input bit calm);
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  ch;
        logic [FREQ_W-1:0]  freq;
        logic [BYTES_W-1:0] nbytes;
        int unsigned        pick;
        ch     = ($urandom_range(9) == 0) ? CHAN_W'(3) : CHAN_W'($urandom_range(CHANNELS - 1));
        freq   = FREQ_W'($urandom);
        nbytes = BYTES_W'($urandom);
        if ($urandom_range(99) < tick_pct)
        begin
            kind = KIND_TICK;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                kind = KIND_READ_ARM;
            else if (pick < 45)
                kind = KIND_POLL;
            else if (pick < 85)
            begin
                kind = KIND_SET_RATE;
                if (pick < 72)
                begin
                    freq   = good_rate();
                    nbytes = BYTES_W'(REQUIRED_BYTES);
                end
                else if (pick < 78)
                begin
                    freq   = FREQ_W'($urandom_range(0, 1100));
                    nbytes = BYTES_W'(REQUIRED_BYTES);
                end
            end
            else if (pick < 91)
                kind = KIND_W'($urandom_range(6, 7));
            else if (pick < 97)
                kind = calm ? KIND_POLL : KIND_CLOSE;
            else
                kind = calm ? KIND_POLL : KIND_OPEN;
        end
        send_word(kind, ch, freq, nbytes);
        if (kind == KIND_OPEN)
            send_word(KIND_SET_RATE, ch, good_rate(), BYTES_W'(REQUIRED_BYTES));
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (rates.expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            logic [15:0] ready_pattern;
            int unsigned ready_phase;
            ready_phase = 0;
            ready_pattern = 16'hFFFF;
            while (1)
            begin
                @(posedge clk);
                if (ready_phase % 64 == 0)
                begin
                    case ($urandom_range(3))
                        0: ready_pattern = 16'hFFFF;
                        1: ready_pattern = 16'($urandom);
                        2: ready_pattern = 16'($urandom) & 16'($urandom);
                        default: ready_pattern = 16'($urandom) | 16'($urandom);
                    endcase
                    if (ready_pattern == '0)
                        ready_pattern = 16'h0001;
                end
                rsp.ready <= ready_pattern[ready_phase % 16];
                ready_phase++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                rates.check_result(rsp.status, rsp.flag, rsp.all_flags);
            if (req.valid && req.ready)
                rates.note_request(req.kind, req.channel, req.freq_value, req.byte_count);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rates = new();
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.kind       <= KIND_TICK;
        req.channel    <= '0;
        req.freq_value <= '0;
        req.byte_count <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_POLL, 2'd0, 16'h0000, 4'd0);
        send_word(KIND_TICK, 2'd1, 16'hFFFF, 4'hF);
        send_word(KIND_SET_RATE, 2'd0, 16'd2, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'd1024, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'd1024, 4'd3);
        send_word(KIND_SET_RATE, 2'd0, 16'd1024, 4'hF);
        send_word(KIND_SET_RATE, 2'd0, 16'd0, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'd1, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'd3, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'd2048, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'hFFFF, 4'd4);
        send_word(KIND_SET_RATE, 2'd0, 16'h8000, 4'd4);
        send_word(KIND_OPEN, 2'd3, 16'd0, 4'd0);
        send_word(KIND_READ_ARM, 2'd1, 16'd0, 4'd0);
        send_word(KIND_OPEN, 2'd0, 16'd0, 4'd0);
        send_word(KIND_SET_RATE, 2'd0, 16'd1024, 4'd4);
        send_word(KIND_POLL, 2'd0, 16'd0, 4'd0);
        send_word(KIND_CLOSE, 2'd3, 16'd0, 4'd0);
        send_word(KIND_POLL, 2'd3, 16'd0, 4'd0);
        send_word(KIND_W'(6), 2'd1, 16'd0, 4'd0);
        send_word(KIND_W'(7), 2'd2, 16'hFFFF, 4'hF);
        send_word(KIND_OPEN, 2'd1, 16'd0, 4'd0);
        send_word(KIND_OPEN, 2'd2, 16'd0, 4'd0);
        send_word(KIND_CLOSE, 2'd2, 16'd0, 4'd0);
        send_word(KIND_READ_ARM, 2'd0, 16'd0, 4'd0);

        // arm every channel at the fastest reload, then drain the counters
        for (int i = 0; i < CHANNELS; i++)
            send_word(KIND_OPEN, CHAN_W'(i), FREQ_W'($urandom), BYTES_W'($urandom));
        send_word(KIND_SET_RATE, 2'd0, 16'd1024, BYTES_W'(REQUIRED_BYTES));
        repeat (620) send_random(88, 1'b1);

        drain_results();

        repeat (650) send_random(50, 1'b0);

        req.valid <= 1'b0;
        @(posedge clk);
        while (rates.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (rates.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/vrrd_pkg.sv
sv/vrrd_req_if.sv
sv/vrrd_rsp_if.sv
sv/vrrd_front.sv
sv/vrrd_queue.sv
sv/vrrd_back.sv
sv/virtual_rtc_rate_divider.sv
tb/sv/virtual_rtc_rate_divider_test.sv
